@@ rtl/word_tokenizer_assert.svh @@
// Assertion macros used by the word tokenizer back end, wt_back.
// Each macro checks one property clocked on the rising edge, held off during reset.
`ifndef WORD_TOKENIZER_ASSERT_SVH
`define WORD_TOKENIZER_ASSERT_SVH

// Same-cycle implication.
`define WT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define WT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/wt_pkg.sv @@
// Shared types, constants and character helpers for the word tokenizer.
// Used by wt_front, wt_fifo, wt_back and word_tokenizer; no dependencies.
package wt_pkg;

	// Width of the length/index field in a queued op, sized for the longest word.
	localparam int LEN_W = 6;

	localparam logic [7:0] CH_END        = 8'h00;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CASE_OFFSET   = 8'd32;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_FLUSH,
		OP_DONE
	} wt_op_kind_t;

	// WRITE: len = buffer index, data[7:0] = char
	// FLUSH: len = word length, data = token number
	// DONE:  data = token total
	typedef struct packed {
		wt_op_kind_t      kind;
		logic [LEN_W-1:0] len;
		logic [15:0]      data;
	} wt_op_t;

	typedef enum logic {
		BK_IDLE,
		BK_FLUSH
	} wt_back_state_t;

	function automatic logic is_word_byte(input logic [7:0] c);
		logic lower, upper, digit;
		lower = (c >= 8'h61) && (c <= 8'h7A);
		upper = (c >= 8'h41) && (c <= 8'h5A);
		digit = (c >= 8'h30) && (c <= 8'h39);
		return lower || upper || digit || (c == CH_UNDERSCORE);
	endfunction

	function automatic logic [7:0] fold_lower(input logic [7:0] c);
		logic upper;
		upper = (c >= 8'h41) && (c <= 8'h5A);
		return upper ? (c + CASE_OFFSET) : c;
	endfunction

endpackage

@@ rtl/wt_front.sv @@
// Front end: accepts text bytes, classifies them and queues write/flush/done ops.
// Holds the token limit register and the word length and token counters; uses wt_pkg.
module wt_front #(
	parameter int WORD_LEN_MAX = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [15:0]   token_limit,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [7:0]    text_byte,
	input  logic          q_full,
	output logic          q_push,
	output wt_pkg::wt_op_t q_op
);

	localparam int BUF_DEPTH = WORD_LEN_MAX - 1;
	localparam int LW        = $clog2(WORD_LEN_MAX);

	logic [15:0]   limit_q;
	logic [LW-1:0] len_q, len_n;
	logic [15:0]   tok_q, tok_n;
	logic          lim_q, lim_n;
	logic          done_pend_q, done_pend_n;

	logic        accept;
	logic        blocked;
	logic        len_nz;
	logic [15:0] tok_inc;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full || done_pend_q;
	assign accept    = in_valid && !in_stall;
	assign blocked   = lim_q || (tok_q >= limit_q);
	assign len_nz    = (len_q != '0);
	assign tok_inc   = tok_q + 16'd1;

	always_comb begin
		q_push      = 1'b0;
		q_op.kind   = wt_pkg::OP_WRITE;
		q_op.len    = '0;
		q_op.data   = '0;
		len_n       = len_q;
		tok_n       = tok_q;
		lim_n       = lim_q;
		done_pend_n = done_pend_q;
		if (done_pend_q) begin
			// second op of an end byte that flushed a word
			q_push    = !q_full;
			q_op.kind = wt_pkg::OP_DONE;
			q_op.data = tok_q;
			if (!q_full) begin
				tok_n       = '0;
				lim_n       = 1'b0;
				done_pend_n = 1'b0;
			end
		end else if (accept) begin
			if (text_byte == wt_pkg::CH_END) begin
				q_push = 1'b1;
				len_n  = '0;
				if (len_nz && !blocked) begin
					q_op.kind   = wt_pkg::OP_FLUSH;
					q_op.len    = wt_pkg::LEN_W'(len_q);
					q_op.data   = tok_q;
					tok_n       = tok_inc;
					done_pend_n = 1'b1;
				end else begin
					q_op.kind = wt_pkg::OP_DONE;
					q_op.data = tok_q;
					tok_n     = '0;
					lim_n     = 1'b0;
				end
			end else if (blocked) begin
				len_n = '0;
			end else if (wt_pkg::is_word_byte(text_byte)) begin
				// drop characters past the buffer, keep the word open
				if (len_q < LW'(BUF_DEPTH)) begin
					q_push    = 1'b1;
					q_op.kind = wt_pkg::OP_WRITE;
					q_op.len  = wt_pkg::LEN_W'(len_q);
					q_op.data = {8'h00, wt_pkg::fold_lower(text_byte)};
					len_n     = len_q + LW'(1);
				end
			end else if (len_nz) begin
				q_push    = 1'b1;
				q_op.kind = wt_pkg::OP_FLUSH;
				q_op.len  = wt_pkg::LEN_W'(len_q);
				q_op.data = tok_q;
				tok_n     = tok_inc;
				lim_n     = (tok_inc >= limit_q);
				len_n     = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= 16'hFFFF;
			len_q       <= '0;
			tok_q       <= '0;
			lim_q       <= 1'b0;
			done_pend_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				limit_q <= token_limit;
			end
			len_q       <= len_n;
			tok_q       <= tok_n;
			lim_q       <= lim_n;
			done_pend_q <= done_pend_n;
		end
	end

endmodule

@@ rtl/wt_fifo.sv @@
// Short op queue between the front end and the back end.
// Circular buffer of wt_pkg::wt_op_t entries with full/empty flags.
module wt_fifo #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  wt_pkg::wt_op_t push_op,
	output logic           full,
	input  logic           pop,
	output wt_pkg::wt_op_t pop_op,
	output logic           empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	wt_pkg::wt_op_t entries_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_op  = entries_q[rd_ptr_q];

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

@@ rtl/wt_back.sv @@
// Back end: stores word characters and plays out tokens and done results.
// Holds the word memory, the flush sequencer, a read stage and the output register.
`include "word_tokenizer_assert.svh"

module wt_back #(
	parameter int WORD_LEN_MAX = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  wt_pkg::wt_op_t q_op,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [7:0]     token_char,
	output logic [15:0]    token_number,
	output logic           last_char,
	output logic           text_done,
	output logic [15:0]    token_total
);

	localparam int BUF_DEPTH = WORD_LEN_MAX - 1;
	localparam int IW        = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int LW        = $clog2(WORD_LEN_MAX);

	logic [7:0] word_mem [BUF_DEPTH];

	wt_pkg::wt_back_state_t state_q, state_n;
	logic [LW-1:0] cnt_q, cnt_n;
	logic [LW-1:0] len_q, len_n;
	logic [15:0]   tnum_q, tnum_n;

	logic        valid_s1, done_s1, last_s1;
	logic [15:0] num_s1, total_s1;
	logic [7:0]  rdata_s1;

	logic        out_valid_q, out_last_q, out_done_q;
	logic [7:0]  out_char_q;
	logic [15:0] out_num_q, out_total_q;

	logic        out_adv, s1_free;
	logic        mem_we, rd_en, s1_load;
	logic        s1_done_n, s1_last_n;
	logic [15:0] s1_num_n, s1_total_n;

	assign out_adv = !out_valid_q || !out_stall;
	assign s1_free = !valid_s1 || out_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wt_pkg::BK_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n    = state_q;
		cnt_n      = cnt_q;
		len_n      = len_q;
		tnum_n     = tnum_q;
		q_pop      = 1'b0;
		mem_we     = 1'b0;
		rd_en      = 1'b0;
		s1_load    = 1'b0;
		s1_done_n  = 1'b0;
		s1_last_n  = 1'b0;
		s1_num_n   = '0;
		s1_total_n = '0;
		case (state_q)
			wt_pkg::BK_IDLE: begin
				if (!q_empty) begin
					case (q_op.kind)
						wt_pkg::OP_WRITE: begin
							q_pop  = 1'b1;
							mem_we = 1'b1;
						end
						wt_pkg::OP_FLUSH: begin
							q_pop   = 1'b1;
							cnt_n   = '0;
							len_n   = LW'(q_op.len);
							tnum_n  = q_op.data;
							state_n = wt_pkg::BK_FLUSH;
						end
						wt_pkg::OP_DONE: begin
							if (s1_free) begin
								q_pop      = 1'b1;
								s1_load    = 1'b1;
								s1_done_n  = 1'b1;
								s1_total_n = q_op.data;
							end
						end
						default: begin
							q_pop = 1'b1;
						end
					endcase
				end
			end
			wt_pkg::BK_FLUSH: begin
				// one character read per cycle while the read stage can move
				if (s1_free) begin
					rd_en     = 1'b1;
					s1_load   = 1'b1;
					s1_num_n  = tnum_q;
					s1_last_n = ((cnt_q + LW'(1)) == len_q);
					cnt_n     = cnt_q + LW'(1);
					if (s1_last_n) begin
						state_n = wt_pkg::BK_IDLE;
					end
				end
			end
			default: begin
				state_n = wt_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			len_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_n;
			len_q <= len_n;
			if (s1_load) begin
				valid_s1 <= 1'b1;
			end else if (out_adv) begin
				valid_s1 <= 1'b0;
			end
			if (out_adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		tnum_q <= tnum_n;
		if (mem_we) begin
			word_mem[IW'(q_op.len)] <= q_op.data[7:0];
		end
		if (rd_en) begin
			rdata_s1 <= word_mem[cnt_q[IW-1:0]];
		end
		if (s1_load) begin
			done_s1  <= s1_done_n;
			last_s1  <= s1_last_n;
			num_s1   <= s1_num_n;
			total_s1 <= s1_total_n;
		end
		if (out_adv && valid_s1) begin
			out_char_q  <= done_s1 ? 8'h00 : rdata_s1;
			out_num_q   <= num_s1;
			out_last_q  <= last_s1;
			out_done_q  <= done_s1;
			out_total_q <= total_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign token_char   = out_char_q;
	assign token_number = out_num_q;
	assign last_char    = out_last_q;
	assign text_done    = out_done_q;
	assign token_total  = out_total_q;

	`WT_ASSERT_IMPL(a_flush_len_nonzero, clk, arst_n, q_pop && (q_op.kind == wt_pkg::OP_FLUSH), q_op.len != '0, "flush op with empty word")
	`WT_ASSERT_IMPL(a_pop_not_empty, clk, arst_n, q_pop, !q_empty, "pop from empty op queue")
	`WT_ASSERT_IMPL(a_flush_cnt_range, clk, arst_n, state_q == wt_pkg::BK_FLUSH, cnt_q < len_q, "flush index past word length")
	`WT_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !out_adv, valid_s1 && $stable(rdata_s1), "read stage lost its item")

endmodule

@@ rtl/word_tokenizer.sv @@
// A byte that completes a word passes the op queue, flush sequencer, read stage and output
// register before out_valid has its first character; an end byte with no pending word skips
// the flush sequencer. Throughput: one text byte per cycle into the FIFO_DEPTH op queue. The
// back end stores characters, takes flushes and plays out characters, so input stalls once
// the queue fills, and while an end byte that flushed a word queues its done op.
// Reset (arst_n low, asynchronous) clears counters, queue and output valid; token_limit = 65535.
module word_tokenizer #(
	parameter int WORD_LEN_MAX = 64,
	parameter int FIFO_DEPTH   = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] token_limit,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  token_char,
	output logic [15:0] token_number,
	output logic        last_char,
	output logic        text_done,
	output logic [15:0] token_total
);

	wt_pkg::wt_op_t push_op, pop_op;
	logic           push, pop, full, empty;

	wt_front #(
		.WORD_LEN_MAX(WORD_LEN_MAX)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.token_limit(token_limit),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.text_byte  (text_byte),
		.q_full     (full),
		.q_push     (push),
		.q_op       (push_op)
	);

	wt_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.push_op(push_op),
		.full   (full),
		.pop    (pop),
		.pop_op (pop_op),
		.empty  (empty)
	);

	wt_back #(
		.WORD_LEN_MAX(WORD_LEN_MAX)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (empty),
		.q_op        (pop_op),
		.q_pop       (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.token_char  (token_char),
		.token_number(token_number),
		.last_char   (last_char),
		.text_done   (text_done),
		.token_total (token_total)
	);

endmodule
